FILE: rtl/core/pmc_pkg.sv
// shared types, constants and a helper function of the power meter mppt controller
package pmc_pkg;

  // sample and field widths
  localparam int unsigned ADC_BITS   = 12;
  localparam int unsigned SHIFT_W    = 4;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned DUTY_W     = 17;
  localparam int unsigned DIFF_W     = ADC_BITS + 1;
  localparam int unsigned VALUE_W    = 29;
  localparam int unsigned PROD_W     = 2 * VALUE_W;
  localparam int unsigned POWER_W    = 41;
  localparam int unsigned POWER_LSB  = 16;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned DATA_W     = 32;

  // multiplier operand padding up to the value width
  localparam int unsigned GAIN_PAD   = VALUE_W - GAIN_W;
  localparam int unsigned DIFF_PAD   = VALUE_W - DIFF_W;

  // duty limits in q1.16
  localparam logic [DUTY_W-1:0] DUTY_ONE   = 17'd65536;
  localparam logic [DUTY_W-1:0] DUTY_FLOOR = 17'd3277;

  // reset values
  localparam logic [SHIFT_W-1:0]  FILTER_SHIFT_RST = 4'd5;
  localparam logic [GAIN_W-1:0]   VOLTAGE_GAIN_RST = 16'd160;
  localparam logic [GAIN_W-1:0]   CURRENT_GAIN_RST = 16'd48;
  localparam logic [DUTY_W-1:0]   DUTY_INIT_RST    = 17'd32768;
  localparam logic [DUTY_W-1:0]   DUTY_STEP_RST    = 17'd655;
  localparam logic [ADC_BITS-1:0] VOLTAGE_FILT_RST = 12'd2090;
  localparam logic [ADC_BITS-1:0] CURRENT_FILT_RST = 12'd2048;

  // register indexes
  localparam logic [2:0] REG_FILTER_SHIFT = 3'd0;
  localparam logic [2:0] REG_VOLTAGE_ZERO = 3'd1;
  localparam logic [2:0] REG_CURRENT_ZERO = 3'd2;
  localparam logic [2:0] REG_VOLTAGE_GAIN = 3'd3;
  localparam logic [2:0] REG_CURRENT_GAIN = 3'd4;
  localparam logic [2:0] REG_DUTY_INITIAL = 3'd5;
  localparam logic [2:0] REG_DUTY_STEP    = 3'd6;

  // controller states
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL_V  = 5'b00010,
    ST_MUL_C  = 5'b00100,
    ST_MUL_P  = 5'b01000,
    ST_FINISH = 5'b10000
  } pmc_state_e;

  // configuration seen by the datapath
  typedef struct packed {
    logic [SHIFT_W-1:0]  filter_shift;
    logic [ADC_BITS-1:0] voltage_zero;
    logic [ADC_BITS-1:0] current_zero;
    logic [GAIN_W-1:0]   voltage_gain;
    logic [GAIN_W-1:0]   current_gain;
    logic [DUTY_W-1:0]   duty_step;
  } pmc_cfg_t;

  // duty preload on a duty_initial write
  typedef struct packed {
    logic              load;
    logic [DUTY_W-1:0] value;
  } pmc_duty_load_t;

  // controller commands to the datapath
  typedef struct packed {
    logic load_filt;
    logic mul_v;
    logic mul_c;
    logic mul_p;
    logic finish;
  } pmc_cmd_t;

  // shift-based exponential filter step
  function automatic logic [ADC_BITS-1:0] filt_step(
    input logic [ADC_BITS-1:0] prev,
    input logic [ADC_BITS-1:0] sample,
    input logic [SHIFT_W-1:0]  shift
  );
    logic [ADC_BITS:0] acc;
    acc = {1'b0, prev} - {1'b0, prev >> shift} + {1'b0, sample >> shift};
    return acc[ADC_BITS-1:0];
  endfunction

endpackage

FILE: rtl/core/pmc_if.sv
// input and result channel interfaces of the power meter mppt controller

// sample word channel
interface pmc_in_if;
  logic                          valid;
  logic                          ready;
  logic [pmc_pkg::ADC_BITS-1:0]  voltage_sample;
  logic [pmc_pkg::ADC_BITS-1:0]  current_sample;

  modport source (output valid, output voltage_sample, output current_sample, input ready);
  modport sink (input valid, input voltage_sample, input current_sample, output ready);
endinterface

// result word channel
interface pmc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pmc_pkg::VALUE_W-1:0]  voltage_value;
  logic signed [pmc_pkg::VALUE_W-1:0]  current_value;
  logic signed [pmc_pkg::POWER_W-1:0]  power_value;
  logic [pmc_pkg::DUTY_W-1:0]          duty_applied;
  logic [pmc_pkg::DUTY_W-1:0]          duty_next;

  modport source (
    output valid, output voltage_value, output current_value, output power_value,
    output duty_applied, output duty_next, input ready
  );
  modport sink (
    input valid, input voltage_value, input current_value, input power_value,
    input duty_applied, input duty_next, output ready
  );
endinterface

FILE: rtl/core/pmc_regs.sv
// apb configuration registers of the power meter mppt controller
module pmc_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pmc_pkg::ADDR_W-1:0]    paddr,
  input  logic [pmc_pkg::DATA_W-1:0]    pwdata,
  output logic [pmc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output pmc_pkg::pmc_cfg_t             cfg_o,
  output pmc_pkg::pmc_duty_load_t       duty_load_o
);

  logic [pmc_pkg::SHIFT_W-1:0]  filter_shift_q, filter_shift_d;
  logic [pmc_pkg::ADC_BITS-1:0] voltage_zero_q, voltage_zero_d;
  logic [pmc_pkg::ADC_BITS-1:0] current_zero_q, current_zero_d;
  logic [pmc_pkg::GAIN_W-1:0]   voltage_gain_q, voltage_gain_d;
  logic [pmc_pkg::GAIN_W-1:0]   current_gain_q, current_gain_d;
  logic [pmc_pkg::DUTY_W-1:0]   duty_initial_q, duty_initial_d;
  logic [pmc_pkg::DUTY_W-1:0]   duty_step_q, duty_step_d;
  logic                         wr_en;
  logic [2:0]                   reg_idx;
  logic [pmc_pkg::DUTY_W-1:0]   wr_duty;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign wr_duty = pwdata[pmc_pkg::DUTY_W-1:0];

  // register write decode
  always_comb begin
    filter_shift_d = filter_shift_q;
    voltage_zero_d = voltage_zero_q;
    current_zero_d = current_zero_q;
    voltage_gain_d = voltage_gain_q;
    current_gain_d = current_gain_q;
    duty_initial_d = duty_initial_q;
    duty_step_d    = duty_step_q;
    if (wr_en) begin
      case (reg_idx)
        pmc_pkg::REG_FILTER_SHIFT: filter_shift_d = pwdata[pmc_pkg::SHIFT_W-1:0];
        pmc_pkg::REG_VOLTAGE_ZERO: voltage_zero_d = pwdata[pmc_pkg::ADC_BITS-1:0];
        pmc_pkg::REG_CURRENT_ZERO: current_zero_d = pwdata[pmc_pkg::ADC_BITS-1:0];
        pmc_pkg::REG_VOLTAGE_GAIN: voltage_gain_d = pwdata[pmc_pkg::GAIN_W-1:0];
        pmc_pkg::REG_CURRENT_GAIN: current_gain_d = pwdata[pmc_pkg::GAIN_W-1:0];
        pmc_pkg::REG_DUTY_INITIAL: duty_initial_d = wr_duty;
        pmc_pkg::REG_DUTY_STEP:    duty_step_d    = wr_duty;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_shift_q <= pmc_pkg::FILTER_SHIFT_RST;
      voltage_zero_q <= '0;
      current_zero_q <= '0;
      voltage_gain_q <= pmc_pkg::VOLTAGE_GAIN_RST;
      current_gain_q <= pmc_pkg::CURRENT_GAIN_RST;
      duty_initial_q <= pmc_pkg::DUTY_INIT_RST;
      duty_step_q    <= pmc_pkg::DUTY_STEP_RST;
    end else begin
      filter_shift_q <= filter_shift_d;
      voltage_zero_q <= voltage_zero_d;
      current_zero_q <= current_zero_d;
      voltage_gain_q <= voltage_gain_d;
      current_gain_q <= current_gain_d;
      duty_initial_q <= duty_initial_d;
      duty_step_q    <= duty_step_d;
    end
  end

  // duty preload, saturated at one
  always_comb begin
    duty_load_o.load  = wr_en && (reg_idx == pmc_pkg::REG_DUTY_INITIAL);
    duty_load_o.value = (wr_duty > pmc_pkg::DUTY_ONE) ? pmc_pkg::DUTY_ONE : wr_duty;
  end

  // read back
  always_comb begin
    prdata = '0;
    case (reg_idx)
      pmc_pkg::REG_FILTER_SHIFT: prdata = {28'd0, filter_shift_q};
      pmc_pkg::REG_VOLTAGE_ZERO: prdata = {20'd0, voltage_zero_q};
      pmc_pkg::REG_CURRENT_ZERO: prdata = {20'd0, current_zero_q};
      pmc_pkg::REG_VOLTAGE_GAIN: prdata = {16'd0, voltage_gain_q};
      pmc_pkg::REG_CURRENT_GAIN: prdata = {16'd0, current_gain_q};
      pmc_pkg::REG_DUTY_INITIAL: prdata = {15'd0, duty_initial_q};
      pmc_pkg::REG_DUTY_STEP:    prdata = {15'd0, duty_step_q};
      default:                   prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.filter_shift = filter_shift_q;
    cfg_o.voltage_zero = voltage_zero_q;
    cfg_o.current_zero = current_zero_q;
    cfg_o.voltage_gain = voltage_gain_q;
    cfg_o.current_gain = current_gain_q;
    cfg_o.duty_step    = duty_step_q;
  end

endmodule

FILE: rtl/core/pmc_ctrl.sv
// sequencing state machine of the power meter mppt controller
module pmc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pmc_pkg::pmc_cmd_t cmd_o
);

  pmc_pkg::pmc_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                finish_ok;
  logic                accept;

  // result can be written when the output slot is free or being emptied
  assign finish_ok   = (state_q == pmc_pkg::ST_FINISH) && (!out_valid_q || out_ready_i);
  assign in_ready_o  = (state_q == pmc_pkg::ST_IDLE) || finish_ok;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pmc_pkg::ST_IDLE: begin
        if (accept) state_d = pmc_pkg::ST_MUL_V;
      end
      pmc_pkg::ST_MUL_V: state_d = pmc_pkg::ST_MUL_C;
      pmc_pkg::ST_MUL_C: state_d = pmc_pkg::ST_MUL_P;
      pmc_pkg::ST_MUL_P: state_d = pmc_pkg::ST_FINISH;
      pmc_pkg::ST_FINISH: begin
        if (finish_ok) state_d = accept ? pmc_pkg::ST_MUL_V : pmc_pkg::ST_IDLE;
      end
      default: state_d = pmc_pkg::ST_IDLE;
    endcase
  end

  // output slot occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (finish_ok) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pmc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath commands
  always_comb begin
    cmd_o.load_filt = accept;
    cmd_o.mul_v     = (state_q == pmc_pkg::ST_MUL_V);
    cmd_o.mul_c     = (state_q == pmc_pkg::ST_MUL_C);
    cmd_o.mul_p     = (state_q == pmc_pkg::ST_MUL_P);
    cmd_o.finish    = finish_ok;
  end

endmodule

FILE: rtl/core/pmc_datapath.sv
// filters, shared multiplier and mppt decision of the power meter mppt controller
module pmc_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pmc_pkg::pmc_cmd_t                   cmd_i,
  input  pmc_pkg::pmc_cfg_t                   cfg_i,
  input  pmc_pkg::pmc_duty_load_t             duty_load_i,
  input  logic [pmc_pkg::ADC_BITS-1:0]        voltage_sample_i,
  input  logic [pmc_pkg::ADC_BITS-1:0]        current_sample_i,
  output logic signed [pmc_pkg::VALUE_W-1:0]  voltage_value_o,
  output logic signed [pmc_pkg::VALUE_W-1:0]  current_value_o,
  output logic signed [pmc_pkg::POWER_W-1:0]  power_value_o,
  output logic [pmc_pkg::DUTY_W-1:0]          duty_applied_o,
  output logic [pmc_pkg::DUTY_W-1:0]          duty_next_o
);

  // mppt state
  logic [pmc_pkg::ADC_BITS-1:0]       vfilt_q, vfilt_d;
  logic [pmc_pkg::ADC_BITS-1:0]       cfilt_q, cfilt_d;
  logic signed [pmc_pkg::POWER_W-1:0] best_q, best_d;
  logic [pmc_pkg::DUTY_W-1:0]         saved_q, saved_d;
  logic [pmc_pkg::DUTY_W-1:0]         duty_q, duty_d;

  // intermediate and result words
  logic signed [pmc_pkg::VALUE_W-1:0] v_q, c_q;
  logic signed [pmc_pkg::PROD_W-1:0]  prod_q;
  logic signed [pmc_pkg::VALUE_W-1:0] res_v_q, res_c_q;
  logic signed [pmc_pkg::POWER_W-1:0] res_p_q;
  logic [pmc_pkg::DUTY_W-1:0]         res_applied_q, res_next_q;

  logic signed [pmc_pkg::DIFF_W-1:0]  vdiff, cdiff;
  logic signed [pmc_pkg::VALUE_W-1:0] mul_a, mul_b;
  logic signed [pmc_pkg::PROD_W-1:0]  mul_y;
  logic signed [pmc_pkg::POWER_W-1:0] power;
  logic                               better;
  logic [pmc_pkg::DUTY_W:0]           duty_up;
  logic signed [pmc_pkg::DUTY_W+1:0]  duty_down;
  logic [pmc_pkg::DUTY_W-1:0]         duty_new;

  // offset removal
  assign vdiff = $signed({1'b0, vfilt_q}) - $signed({1'b0, cfg_i.voltage_zero});
  assign cdiff = $signed({1'b0, cfilt_q}) - $signed({1'b0, cfg_i.current_zero});

  // shared multiplier operand select
  always_comb begin
    if (cmd_i.mul_v) begin
      mul_a = {{pmc_pkg::DIFF_PAD{vdiff[pmc_pkg::DIFF_W-1]}}, vdiff};
      mul_b = $signed({{pmc_pkg::GAIN_PAD{1'b0}}, cfg_i.voltage_gain});
    end else if (cmd_i.mul_c) begin
      mul_a = {{pmc_pkg::DIFF_PAD{cdiff[pmc_pkg::DIFF_W-1]}}, cdiff};
      mul_b = $signed({{pmc_pkg::GAIN_PAD{1'b0}}, cfg_i.current_gain});
    end else begin
      mul_a = v_q;
      mul_b = c_q;
    end
  end

  assign mul_y = mul_a * mul_b;

  // product registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_v) v_q <= mul_y[pmc_pkg::VALUE_W-1:0];
    if (cmd_i.mul_c) c_q <= mul_y[pmc_pkg::VALUE_W-1:0];
    if (cmd_i.mul_p) prod_q <= mul_y;
  end

  // arithmetic shift by 16 floors toward minus infinity
  assign power  = prod_q[pmc_pkg::POWER_LSB +: pmc_pkg::POWER_W];
  assign better = power > best_q;

  // duty step up clamped at one, step down clamped at the floor
  assign duty_up   = {1'b0, duty_q} + {1'b0, cfg_i.duty_step};
  assign duty_down = $signed({2'b00, saved_q}) - $signed({2'b00, cfg_i.duty_step});

  always_comb begin
    if (better) begin
      duty_new = (duty_up > {1'b0, pmc_pkg::DUTY_ONE}) ? pmc_pkg::DUTY_ONE
                                                        : duty_up[pmc_pkg::DUTY_W-1:0];
    end else if (duty_down < $signed({2'b00, pmc_pkg::DUTY_FLOOR})) begin
      duty_new = pmc_pkg::DUTY_FLOOR;
    end else begin
      duty_new = duty_down[pmc_pkg::DUTY_W-1:0];
    end
  end

  // state update
  always_comb begin
    vfilt_d = vfilt_q;
    cfilt_d = cfilt_q;
    best_d  = best_q;
    saved_d = saved_q;
    duty_d  = duty_q;
    if (cmd_i.load_filt) begin
      vfilt_d = pmc_pkg::filt_step(vfilt_q, voltage_sample_i, cfg_i.filter_shift);
      cfilt_d = pmc_pkg::filt_step(cfilt_q, current_sample_i, cfg_i.filter_shift);
    end
    if (cmd_i.finish) begin
      duty_d = duty_new;
      if (better) begin
        best_d  = power;
        saved_d = duty_q;
      end else begin
        best_d  = '0;
      end
    end
    if (duty_load_i.load) begin
      duty_d = duty_load_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vfilt_q <= pmc_pkg::VOLTAGE_FILT_RST;
      cfilt_q <= pmc_pkg::CURRENT_FILT_RST;
      best_q  <= '0;
      saved_q <= '0;
      duty_q  <= pmc_pkg::DUTY_INIT_RST;
    end else begin
      vfilt_q <= vfilt_d;
      cfilt_q <= cfilt_d;
      best_q  <= best_d;
      saved_q <= saved_d;
      duty_q  <= duty_d;
    end
  end

  // result word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_v_q       <= v_q;
      res_c_q       <= c_q;
      res_p_q       <= power;
      res_applied_q <= duty_q;
      res_next_q    <= duty_new;
    end
  end

  assign voltage_value_o = res_v_q;
  assign current_value_o = res_c_q;
  assign power_value_o   = res_p_q;
  assign duty_applied_o  = res_applied_q;
  assign duty_next_o     = res_next_q;

endmodule

FILE: rtl/core/power_meter_mppt_controller.sv
// power meter with perturb-and-observe mppt, top level
// a result word is valid after the filter update and the voltage, current
//   and power products on the single shared 29x29 multiplier, followed by
//   the mppt decision, which waits while the output slot is still full
// a new sample word is taken in the cycle its predecessor's result is written
// reset (async, active low): filters 2090/2048, duty 32768, best power and
//   saved duty zero, registers at their defaults, no result pending
module power_meter_mppt_controller (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  pmc_in_if.sink                      sample_i,
  pmc_out_if.source                   result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pmc_pkg::ADDR_W-1:0]  paddr,
  input  logic [pmc_pkg::DATA_W-1:0]  pwdata,
  output logic [pmc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  pmc_pkg::pmc_cfg_t       cfg;
  pmc_pkg::pmc_duty_load_t duty_load;
  pmc_pkg::pmc_cmd_t       cmd;

  // configuration registers
  pmc_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cfg_o       (cfg),
    .duty_load_o (duty_load)
  );

  // sequencer
  pmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd)
  );

  // arithmetic and mppt state
  pmc_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_i            (cfg),
    .duty_load_i      (duty_load),
    .voltage_sample_i (sample_i.voltage_sample),
    .current_sample_i (sample_i.current_sample),
    .voltage_value_o  (result_o.voltage_value),
    .current_value_o  (result_o.current_value),
    .power_value_o    (result_o.power_value),
    .duty_applied_o   (result_o.duty_applied),
    .duty_next_o      (result_o.duty_next)
  );

endmodule

FILE: rtl/core/pmc_checker.sv
// port-level assertions of the power meter mppt controller and their binding
module pmc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [pmc_pkg::DUTY_W-1:0]  duty_applied_i,
  input logic [pmc_pkg::DUTY_W-1:0]  duty_next_i,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [pmc_pkg::ADDR_W-1:0]  paddr
);

  logic                       have_q, have_d;
  logic [pmc_pkg::DUTY_W-1:0] last_q, last_d;
  logic                       duty_wr;

  assign duty_wr = psel && penable && pwrite && (paddr[4:2] == pmc_pkg::REG_DUTY_INITIAL);

  // duty chosen by the last delivered word, forgotten on a duty preload
  always_comb begin
    have_d = have_q;
    last_d = last_q;
    if (out_valid_i && out_ready_i) begin
      have_d = 1'b1;
      last_d = duty_next_i;
    end
    if (duty_wr) begin
      have_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      last_q <= '0;
    end else begin
      have_q <= have_d;
      last_q <= last_d;
    end
  end

  // a pending result word stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped before it was taken");

  // a pending result word keeps its duty fields
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(duty_applied_i) && $stable(duty_next_i))
    else $error("pending result word changed");

  // duty never exceeds one
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (duty_applied_i <= pmc_pkg::DUTY_ONE) &&
                    (duty_next_i <= pmc_pkg::DUTY_ONE))
    else $error("duty above one");

  // the duty applied follows the duty chosen in the previous period
  a_duty_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && have_q |-> duty_applied_i == last_q)
    else $error("duty applied differs from previous duty next");

  // the multi-cycle sequence cannot take two sample words in a row
  a_in_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("sample words accepted back to back");

endmodule

bind power_meter_mppt_controller pmc_checker u_pmc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (sample_i.valid),
  .in_ready_i     (sample_i.ready),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .duty_applied_i (result_o.duty_applied),
  .duty_next_i    (result_o.duty_next),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .paddr          (paddr)
);

FILE: sim/tb_power_meter_mppt_controller.sv
`timescale 1ns / 1ps
// self-checking testbench of the power meter mppt controller: directed table, then random words
module tb_power_meter_mppt_controller;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned RANDOM_WORDS = 1900;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned MAX_PRINTS   = 100;
  // index past the register map, writes must be ignored
  localparam logic [2:0]  REG_UNMAPPED = 3'd7;

  // one result word as the meter reports it
  typedef struct {
    logic signed [pmc_pkg::VALUE_W-1:0] volt;
    logic signed [pmc_pkg::VALUE_W-1:0] amp;
    logic signed [pmc_pkg::POWER_W-1:0] watt;
    logic [pmc_pkg::DUTY_W-1:0]         duty_app;
    logic [pmc_pkg::DUTY_W-1:0]         duty_nxt;
  } meter_word_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_WORD, ROW_WORD_TYPED} row_kind_e;

  // one line of the directed table
  typedef struct {
    row_kind_e                    kind;
    logic [2:0]                   reg_idx;
    logic [pmc_pkg::DATA_W-1:0]   data;
    logic [pmc_pkg::ADC_BITS-1:0] vs;
    logic [pmc_pkg::ADC_BITS-1:0] cs;
    meter_word_t                  typed;
  } dir_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_e;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [pmc_pkg::ADDR_W-1:0] paddr;
  logic [pmc_pkg::DATA_W-1:0] pwdata;
  logic [pmc_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  pmc_in_if  sample_if ();
  pmc_out_if result_if ();

  power_meter_mppt_controller u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the meter settings and tracker state
  logic [pmc_pkg::SHIFT_W-1:0]  fshift;
  logic [pmc_pkg::ADC_BITS-1:0] vzero;
  logic [pmc_pkg::ADC_BITS-1:0] czero;
  logic [pmc_pkg::GAIN_W-1:0]   vgain;
  logic [pmc_pkg::GAIN_W-1:0]   cgain;
  logic [pmc_pkg::DUTY_W-1:0]   dstep;
  logic [pmc_pkg::ADC_BITS-1:0] vfilt;
  logic [pmc_pkg::ADC_BITS-1:0] cfilt;
  longint                       best_pw;
  logic [pmc_pkg::DUTY_W-1:0]   saved_duty;
  logic [pmc_pkg::DUTY_W-1:0]   duty_cur;

  meter_word_t words_due[$];
  int          err_count   = 0;
  int          cycle_count = 0;
  int          burst_left  = 0;
  bit          offering    = 1'b0;

  task automatic report_error(input string msg);
    if (err_count < MAX_PRINTS) $display("[%0t] ERROR: %s", $time, msg);
    err_count++;
  endtask

  // exponential filter with a shift as its weight
  function automatic logic [pmc_pkg::ADC_BITS-1:0] ema_step(
    input logic [pmc_pkg::ADC_BITS-1:0] prev,
    input logic [pmc_pkg::ADC_BITS-1:0] smp
  );
    int acc;
    acc = int'(prev) - int'(prev >> fshift) + int'(smp >> fshift);
    return acc[pmc_pkg::ADC_BITS-1:0];
  endfunction

  // one control period: filter, calibrate, power, perturb and observe
  function automatic meter_word_t meter_predict(input logic [pmc_pkg::ADC_BITS-1:0] vs,
                                                input logic [pmc_pkg::ADC_BITS-1:0] cs);
    meter_word_t w;
    longint      v;
    longint      c;
    longint      p;
    longint      nd;
    w.duty_app = duty_cur;
    vfilt = ema_step(vfilt, vs);
    cfilt = ema_step(cfilt, cs);
    v = (longint'(vfilt) - longint'(vzero)) * longint'(vgain);
    c = (longint'(cfilt) - longint'(czero)) * longint'(cgain);
    p = (v * c) >>> pmc_pkg::POWER_LSB;
    if (p > best_pw) begin
      best_pw    = p;
      saved_duty = duty_cur;
      nd = longint'(duty_cur) + longint'(dstep);
      if (nd > longint'(pmc_pkg::DUTY_ONE)) nd = longint'(pmc_pkg::DUTY_ONE);
    end else begin
      nd = longint'(saved_duty) - longint'(dstep);
      if (nd < longint'(pmc_pkg::DUTY_FLOOR)) nd = longint'(pmc_pkg::DUTY_FLOOR);
      best_pw = 0;
    end
    duty_cur   = nd[pmc_pkg::DUTY_W-1:0];
    w.volt     = v[pmc_pkg::VALUE_W-1:0];
    w.amp      = c[pmc_pkg::VALUE_W-1:0];
    w.watt     = p[pmc_pkg::POWER_W-1:0];
    w.duty_nxt = duty_cur;
    return w;
  endfunction

  function automatic dir_row_t cfg_row(input logic [2:0] idx,
                                       input logic [pmc_pkg::DATA_W-1:0] val);
    dir_row_t r;
    r.kind    = ROW_WRITE;
    r.reg_idx = idx;
    r.data    = val;
    return r;
  endfunction

  function automatic dir_row_t word_row(input int vs, input int cs);
    dir_row_t r;
    r.kind = ROW_WORD;
    r.vs   = vs[pmc_pkg::ADC_BITS-1:0];
    r.cs   = cs[pmc_pkg::ADC_BITS-1:0];
    return r;
  endfunction

  function automatic dir_row_t typed_row(input int vs, input int cs, input longint v,
                                         input longint c, input longint p,
                                         input int da, input int dn);
    dir_row_t r;
    r = word_row(vs, cs);
    r.kind           = ROW_WORD_TYPED;
    r.typed.volt     = v[pmc_pkg::VALUE_W-1:0];
    r.typed.amp      = c[pmc_pkg::VALUE_W-1:0];
    r.typed.watt     = p[pmc_pkg::POWER_W-1:0];
    r.typed.duty_app = da[pmc_pkg::DUTY_W-1:0];
    r.typed.duty_nxt = dn[pmc_pkg::DUTY_W-1:0];
    return r;
  endfunction

  function automatic int clamp_adc(input int x);
    if (x < 0) return 0;
    if (x > 4095) return 4095;
    return x;
  endfunction

  // register write: setup and access phases, then the bus goes idle
  task automatic reg_write(input logic [2:0] idx, input logic [pmc_pkg::DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= pmc_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      pmc_pkg::REG_FILTER_SHIFT: fshift = val[pmc_pkg::SHIFT_W-1:0];
      pmc_pkg::REG_VOLTAGE_ZERO: vzero  = val[pmc_pkg::ADC_BITS-1:0];
      pmc_pkg::REG_CURRENT_ZERO: czero  = val[pmc_pkg::ADC_BITS-1:0];
      pmc_pkg::REG_VOLTAGE_GAIN: vgain  = val[pmc_pkg::GAIN_W-1:0];
      pmc_pkg::REG_CURRENT_GAIN: cgain  = val[pmc_pkg::GAIN_W-1:0];
      pmc_pkg::REG_DUTY_INITIAL: begin
        duty_cur = (val[pmc_pkg::DUTY_W-1:0] > pmc_pkg::DUTY_ONE) ? pmc_pkg::DUTY_ONE
                                                                  : val[pmc_pkg::DUTY_W-1:0];
      end
      pmc_pkg::REG_DUTY_STEP:    dstep  = val[pmc_pkg::DUTY_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // offer one sample word, bursts with random gaps in between
  task automatic send_word(input logic [pmc_pkg::ADC_BITS-1:0] vs,
                           input logic [pmc_pkg::ADC_BITS-1:0] cs,
                           input bit use_typed, input meter_word_t typed);
    meter_word_t w;
    int          gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        if (offering) sample_if.valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    sample_if.valid          <= 1'b1;
    sample_if.voltage_sample <= vs;
    sample_if.current_sample <= cs;
    offering = 1'b1;
    do @(posedge clk_i); while (!sample_if.ready);
    w = meter_predict(vs, cs);
    words_due.push_back(use_typed ? typed : w);
  endtask

  // stop offering and wait for every pending result word
  task automatic settle_idle();
    if (offering) sample_if.valid <= 1'b0;
    offering = 1'b0;
    while (words_due.size() != 0) @(posedge clk_i);
  endtask

  // result receiver with its own stall pattern
  rx_mode_e   rx_mode    = RX_OPEN;
  logic [7:0] stall_pat  = 8'hff;
  int         stall_left = 0;

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      rx_mode    <= rx_mode_e'($urandom_range(0, 3));
      stall_pat  <= 8'($urandom()) | 8'h01;
      stall_left <= $urandom_range(16, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   result_if.ready <= 1'b1;
      RX_COIN:   result_if.ready <= ($urandom_range(0, 1) == 0);
      RX_SPARSE: result_if.ready <= ($urandom_range(0, 4) == 0);
      default:   result_if.ready <= stall_pat[stall_left % 8];
    endcase
  end

  // compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin : check_word
    meter_word_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (words_due.size() == 0) begin
        report_error("result word with no sample word pending");
      end else begin
        want = words_due.pop_front();
        if (result_if.voltage_value !== want.volt)
          report_error($sformatf("voltage_value %0d, want %0d",
                                 result_if.voltage_value, want.volt));
        if (result_if.current_value !== want.amp)
          report_error($sformatf("current_value %0d, want %0d",
                                 result_if.current_value, want.amp));
        if (result_if.power_value !== want.watt)
          report_error($sformatf("power_value %0d, want %0d",
                                 result_if.power_value, want.watt));
        if (result_if.duty_applied !== want.duty_app)
          report_error($sformatf("duty_applied %0d, want %0d",
                                 result_if.duty_applied, want.duty_app));
        if (result_if.duty_next !== want.duty_nxt)
          report_error($sformatf("duty_next %0d, want %0d",
                                 result_if.duty_next, want.duty_nxt));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    dir_row_t                     rows[$];
    meter_word_t                  none;
    logic [pmc_pkg::ADC_BITS-1:0] vs;
    logic [pmc_pkg::ADC_BITS-1:0] cs;
    logic [pmc_pkg::DATA_W-1:0]   val;
    int                           base_v;
    int                           base_c;
    int                           phase_len;
    int                           n_sent;
    int                           sel;
    bit                           first_pass;

    rst_ni                   = 1'b0;
    psel                     = 1'b0;
    penable                  = 1'b0;
    pwrite                   = 1'b0;
    paddr                    = '0;
    pwdata                   = '0;
    sample_if.valid          = 1'b0;
    sample_if.voltage_sample = '0;
    sample_if.current_sample = '0;

    fshift     = pmc_pkg::FILTER_SHIFT_RST;
    vzero      = '0;
    czero      = '0;
    vgain      = pmc_pkg::VOLTAGE_GAIN_RST;
    cgain      = pmc_pkg::CURRENT_GAIN_RST;
    dstep      = pmc_pkg::DUTY_STEP_RST;
    vfilt      = pmc_pkg::VOLTAGE_FILT_RST;
    cfilt      = pmc_pkg::CURRENT_FILT_RST;
    best_pw    = 0;
    saved_duty = '0;
    duty_cur   = pmc_pkg::DUTY_INIT_RST;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows = '{
      // after reset, filters sit at their start values
      typed_row(2090, 2048, 334400, 98304, 501600, 32768, 33423),
      typed_row(2090, 2048, 334400, 98304, 501600, 33423, 32113),
      word_row(4095, 4095),
      word_row(0, 0),
      // no filtering, full-scale gains and duty extremes
      cfg_row(pmc_pkg::REG_FILTER_SHIFT, 32'd0),
      cfg_row(pmc_pkg::REG_VOLTAGE_ZERO, 32'd4095),
      cfg_row(pmc_pkg::REG_CURRENT_ZERO, 32'd0),
      cfg_row(pmc_pkg::REG_VOLTAGE_GAIN, 32'd65535),
      cfg_row(pmc_pkg::REG_CURRENT_GAIN, 32'd65535),
      cfg_row(pmc_pkg::REG_DUTY_INITIAL, 32'd65536),
      cfg_row(pmc_pkg::REG_DUTY_STEP, 32'd65536),
      word_row(0, 4095),
      word_row(4095, 4095),
      cfg_row(pmc_pkg::REG_VOLTAGE_ZERO, 32'd0),
      cfg_row(pmc_pkg::REG_CURRENT_ZERO, 32'd4095),
      word_row(4095, 0),
      cfg_row(pmc_pkg::REG_CURRENT_ZERO, 32'd0),
      // largest power, duty clamps at one then at the floor
      word_row(4095, 4095),
      word_row(4095, 4095),
      // small negative power rounds toward minus infinity
      cfg_row(pmc_pkg::REG_VOLTAGE_ZERO, 32'd1),
      cfg_row(pmc_pkg::REG_VOLTAGE_GAIN, 32'd1),
      cfg_row(pmc_pkg::REG_CURRENT_GAIN, 32'd1),
      cfg_row(pmc_pkg::REG_DUTY_STEP, 32'd0),
      word_row(0, 1),
      word_row(2, 3),
      // shift beyond the sample width holds the filters
      cfg_row(pmc_pkg::REG_FILTER_SHIFT, 32'd15),
      cfg_row(pmc_pkg::REG_DUTY_INITIAL, 32'd131071),
      cfg_row(REG_UNMAPPED, 32'hffffffff),
      word_row(4095, 4095),
      word_row(0, 0),
      cfg_row(pmc_pkg::REG_FILTER_SHIFT, 32'd12),
      cfg_row(pmc_pkg::REG_DUTY_STEP, 32'd131071),
      cfg_row(pmc_pkg::REG_DUTY_INITIAL, 32'd0),
      word_row(1234, 3000),
      word_row(4095, 0),
      // strongest listed filter, default gains
      cfg_row(pmc_pkg::REG_FILTER_SHIFT, 32'd11),
      cfg_row(pmc_pkg::REG_VOLTAGE_GAIN, 32'd160),
      cfg_row(pmc_pkg::REG_CURRENT_GAIN, 32'd48),
      cfg_row(pmc_pkg::REG_DUTY_STEP, 32'd655),
      word_row(4095, 4095),
      word_row(0, 0),
      word_row(2730, 1365),
      word_row(1365, 2730)
    };

    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_WRITE: begin
          settle_idle();
          reg_write(rows[i].reg_idx, rows[i].data);
        end
        ROW_WORD:  send_word(rows[i].vs, rows[i].cs, 1'b0, rows[i].typed);
        default:   send_word(rows[i].vs, rows[i].cs, 1'b1, rows[i].typed);
      endcase
    end

    // random phases: new settings, then a drifting sample stream
    n_sent     = 0;
    first_pass = 1'b1;
    while (n_sent < RANDOM_WORDS) begin
      settle_idle();
      for (int r = 0; r < 8; r++) begin
        if (!first_pass && $urandom_range(0, 1) == 0) continue;
        sel = $urandom_range(0, 9);
        case (r[2:0])
          pmc_pkg::REG_FILTER_SHIFT:
            val = (sel == 0) ? 0 : (sel == 1) ? 11 : (sel == 2) ? 15 :
                  (sel == 3) ? $urandom_range(12, 15) : $urandom_range(1, 6);
          pmc_pkg::REG_VOLTAGE_ZERO, pmc_pkg::REG_CURRENT_ZERO:
            val = (sel == 0) ? 0 : (sel == 1) ? 4095 :
                  (sel < 5) ? $urandom_range(1848, 2248) : $urandom_range(0, 4095);
          pmc_pkg::REG_VOLTAGE_GAIN, pmc_pkg::REG_CURRENT_GAIN:
            val = (sel == 0) ? 0 : (sel == 1) ? 65535 :
                  (sel == 2) ? $urandom_range(1, 512) : $urandom_range(0, 65535);
          pmc_pkg::REG_DUTY_INITIAL:
            val = (sel == 0) ? 0 : (sel == 1) ? 65536 :
                  (sel == 2) ? 131071 : $urandom_range(0, 65536);
          pmc_pkg::REG_DUTY_STEP:
            val = (sel == 0) ? 0 : (sel == 1) ? 65536 :
                  (sel == 2) ? 131071 : $urandom_range(1, 4000);
          default: begin
            if ($urandom_range(0, 7) != 0) continue;
            val = $urandom();
          end
        endcase
        // upper data bits beyond the register must be ignored
        if ($urandom_range(0, 3) == 0) val = val | ($urandom() & 32'hfffc0000);
        reg_write(r[2:0], val);
      end
      first_pass = 1'b0;

      phase_len = $urandom_range(20, 120);
      base_v    = $urandom_range(0, 4095);
      base_c    = $urandom_range(0, 4095);
      for (int k = 0; k < phase_len && n_sent < RANDOM_WORDS; k++) begin
        case ($urandom_range(0, 19))
          0, 1: begin
            vs = $urandom_range(0, 4095);
            cs = $urandom_range(0, 4095);
          end
          2: begin
            base_v = $urandom_range(0, 4095);
            base_c = $urandom_range(0, 4095);
            vs = base_v;
            cs = base_c;
          end
          default: begin
            base_v = clamp_adc(base_v + int'($urandom_range(0, 64)) - 32);
            base_c = clamp_adc(base_c + int'($urandom_range(0, 64)) - 32);
            vs = clamp_adc(base_v + int'($urandom_range(0, 8)) - 4);
            cs = clamp_adc(base_c + int'($urandom_range(0, 8)) - 4);
          end
        endcase
        send_word(vs, cs, 1'b0, none);
        n_sent++;
        // now and then hold off until every result word is back
        if ($urandom_range(0, 149) == 0) settle_idle();
      end
    end

    settle_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (words_due.size() != 0) report_error("result words still pending at the end");
    if (err_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
